// ===== sv/aeec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aeec_pkg
// Shared widths, defaults and register indexes of the analog encoder edge
// counter.
// ----------------------------------------------------------------------------
package aeec_pkg;

  localparam int unsigned BURST_LEN_DEF   = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned EDGE_W  = 32;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned IDX_W   = 3;

  localparam logic [CFG_W-1:0]   UPPER_RST  = CFG_W'(2050);
  localparam logic [CFG_W-1:0]   LOWER_RST  = CFG_W'(1950);
  localparam logic [CFG_W-1:0]   TOL_RST    = CFG_W'(50);
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(50);
  localparam logic [CFG_W-1:0]   MARGIN_RST = CFG_W'(100);

  typedef enum logic [IDX_W-1:0] {
    CFG_UPPER  = 3'd0,
    CFG_LOWER  = 3'd1,
    CFG_TOL    = 3'd2,
    CFG_LIMIT  = 3'd3,
    CFG_MARGIN = 3'd4
  } cfg_idx_e;

endpackage
`default_nettype wire

// ===== sv/analog_encoder_edge_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// analog_encoder_edge_counter
// Flow: ST_IDLE takes a burst, ST_CHECK tests it for stillness, ST_RUN walks
//   the clipped sample_count samples (none for a skipped or empty burst) and
//   ST_FINISH loads the result register; one shared crossing unit handles one
//   sample per cycle. A new burst is taken only back in ST_IDLE, and ST_FINISH
//   stays while the result register waits on m_axis_tready_i.
// Reset: asynchronous, active low; clears control state, sets register defaults.
// ----------------------------------------------------------------------------
module analog_encoder_edge_counter #(
  parameter int unsigned BURST_LEN   = aeec_pkg::BURST_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = aeec_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned IN_W  = aeec_pkg::COUNT_W + BURST_LEN * SAMPLE_BITS,
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = aeec_pkg::EDGE_W + SAMPLE_BITS + aeec_pkg::RUN_W,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [aeec_pkg::IDX_W-1:0]      cfg_index_i,
  input  wire logic [aeec_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // sample_count, sample_0 .. sample_(BURST_LEN-1), zero pad
  input  wire logic [IN_TW-1:0]                s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // edge_total, current_level, still_run, zero pad
  output logic [OUT_TW-1:0]                    m_axis_tdata_o,
  // burst_skipped
  output logic                                 m_axis_tuser_o
);

  localparam int unsigned CW  = ((SAMPLE_BITS > aeec_pkg::CFG_W) ? SAMPLE_BITS
                                                                 : aeec_pkg::CFG_W) + 2;
  localparam int unsigned IW  = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned NW  = aeec_pkg::COUNT_W;
  localparam int unsigned RW  = aeec_pkg::RUN_W;
  localparam int unsigned EW  = aeec_pkg::EDGE_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [aeec_pkg::CFG_W-1:0]   upper_q, lower_q, tol_q, margin_q;
  logic [aeec_pkg::LIMIT_W-1:0] limit_q;

  logic [EW-1:0] edge_q, edge_d;
  logic [SB-1:0] cur_q, cur_d;
  logic          rise_q, rise_d, fall_q, fall_d;
  logic [RW-1:0] still_q, still_d;
  logic [SB-1:0] ref_q, ref_d;
  logic          skip_q, skip_d;
  logic [NW-1:0] rem_q, rem_d;

  logic [SB-1:0] samples_q [BURST_LEN];
  logic [SB-1:0] samples_d [BURST_LEN];

  logic          out_valid_q, out_valid_d;
  logic [EW-1:0] out_edge_q;
  logic [SB-1:0] out_level_q;
  logic [RW-1:0] out_run_q;
  logic          out_skip_q;
  logic          out_load;

  logic          in_fire;
  logic [NW-1:0] count_in, count_clip, last_idx;
  logic [SB-1:0] latest, diff;
  logic [RW-1:0] still_new;

  logic signed [CW-1:0] prev_s, cur_s, up_s, dn_s, mg_s, tol_s, diff_s;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready_i);

  assign count_in   = s_axis_tdata_i[NW-1:0];
  assign count_clip = (count_in > NW'(BURST_LEN)) ? NW'(BURST_LEN) : count_in;

  // stillness check on the latched burst
  assign last_idx = (rem_q != '0) ? rem_q - NW'(1) : '0;
  assign latest   = samples_q[last_idx[IW-1:0]];
  assign diff     = (latest >= ref_q) ? latest - ref_q : ref_q - latest;
  assign diff_s   = CW'(diff);
  assign tol_s    = CW'(tol_q);
  assign still_new = (diff_s < tol_s) ? ((still_q != '1) ? still_q + RW'(1) : still_q)
                                      : '0;

  // shared crossing unit operands
  assign prev_s = CW'(cur_q);
  assign cur_s  = CW'(samples_q[0]);
  assign up_s   = CW'(upper_q);
  assign dn_s   = CW'(lower_q);
  assign mg_s   = CW'(margin_q);

  always_comb begin
    state_d     = state_q;
    edge_d      = edge_q;
    cur_d       = cur_q;
    rise_d      = rise_q;
    fall_d      = fall_q;
    still_d     = still_q;
    ref_d       = ref_q;
    skip_d      = skip_q;
    rem_d       = rem_q;
    samples_d   = samples_q;
    out_valid_d = out_valid_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          for (int i = 0; i < BURST_LEN; i++) begin
            samples_d[i] = s_axis_tdata_i[NW + i*SB +: SB];
          end
          rem_d   = count_clip;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        still_d = still_new;
        ref_d   = latest;
        skip_d  = (still_new >= limit_q);
        if ((still_new >= limit_q) || (rem_q == '0)) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cur_d = samples_q[0];
        if (!rise_q && (prev_s <= up_s) && (cur_s > up_s)) begin
          edge_d = edge_q + EW'(1);
          rise_d = 1'b1;
          fall_d = 1'b0;
        end else if (!fall_q && (prev_s >= dn_s) && (cur_s < dn_s)) begin
          edge_d = edge_q + EW'(1);
          fall_d = 1'b1;
          rise_d = 1'b0;
        end
        if (rise_d && (cur_s < dn_s - mg_s)) begin
          rise_d = 1'b0;
        end
        if (fall_d && (cur_s > up_s + mg_s)) begin
          fall_d = 1'b0;
        end
        for (int i = 0; i < BURST_LEN - 1; i++) begin
          samples_d[i] = samples_q[i+1];
        end
        rem_d = rem_q - NW'(1);
        if (rem_q == NW'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upper_q     <= aeec_pkg::UPPER_RST;
      lower_q     <= aeec_pkg::LOWER_RST;
      tol_q       <= aeec_pkg::TOL_RST;
      limit_q     <= aeec_pkg::LIMIT_RST;
      margin_q    <= aeec_pkg::MARGIN_RST;
      edge_q      <= '0;
      cur_q       <= '0;
      rise_q      <= 1'b0;
      fall_q      <= 1'b0;
      still_q     <= '0;
      ref_q       <= '0;
      skip_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      edge_q      <= edge_d;
      cur_q       <= cur_d;
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      still_q     <= still_d;
      ref_q       <= ref_d;
      skip_q      <= skip_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          aeec_pkg::CFG_UPPER:  upper_q  <= cfg_data_i;
          aeec_pkg::CFG_LOWER:  lower_q  <= cfg_data_i;
          aeec_pkg::CFG_TOL:    tol_q    <= cfg_data_i;
          aeec_pkg::CFG_LIMIT:  limit_q  <= cfg_data_i[aeec_pkg::LIMIT_W-1:0];
          aeec_pkg::CFG_MARGIN: margin_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    samples_q <= samples_d;
    if (out_load) begin
      out_edge_q  <= edge_q;
      out_level_q <= cur_q;
      out_run_q   <= still_q;
      out_skip_q  <= skip_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_skip_q;
  assign m_axis_tdata_o  = OUT_TW'({out_run_q, out_level_q, out_edge_q});

endmodule
`default_nettype wire

// ===== test/edge_count_checker.sv =====
// ----------------------------------------------------------------------------
// edge_count_checker
// Watches the register, burst and report channels of the encoder edge
// counter, keeps its own copy of the registers and crossing state, predicts
// the report of every accepted burst and compares each report field by field.
// ----------------------------------------------------------------------------
module edge_count_checker
  import aeec_pkg::*;
#(
  parameter int unsigned IN_TW  = 104,
  parameter int unsigned OUT_TW = 56
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  // sample_count, sample_0 .. sample_7, zero pad
  input  logic [IN_TW-1:0]  s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  // edge_total, current_level, still_run, zero pad
  input  logic [OUT_TW-1:0] m_tdata_i,
  // burst_skipped
  input  logic              m_tuser_i,
  output int                pending_o,
  output int                fail_count_o
);

  localparam int unsigned SB     = SAMPLE_BITS_DEF;
  localparam int unsigned LVL_LO = EDGE_W;
  localparam int unsigned RUN_LO = EDGE_W + SB;

  typedef struct packed {
    logic [EDGE_W-1:0] edges;
    logic              skipped;
    logic [SB-1:0]     level;
    logic [RUN_W-1:0]  run;
  } burst_report_t;

  logic [CFG_W-1:0]   upper_lvl, lower_lvl, tolerance, margin;
  logic [LIMIT_W-1:0] limit;
  logic [EDGE_W-1:0]  edges;
  logic [SB-1:0]      level, last_checked;
  logic               rise_hold, fall_hold;
  logic [RUN_W-1:0]   run;

  burst_report_t burst_reports_q[$];
  burst_report_t got, want;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic burst_report_t predict_burst(input logic [IN_TW-1:0] burst);
    burst_report_t rep;
    int unsigned   n, last;
    int            prev, cur, delta;
    logic [SB-1:0] newest;
    n = burst[COUNT_W-1:0];
    if (n > BURST_LEN_DEF) n = BURST_LEN_DEF;
    last   = (n > 0) ? n - 1 : 0;
    newest = burst[COUNT_W + SB*last +: SB];
    delta  = (newest >= last_checked) ? int'(newest) - int'(last_checked)
                                      : int'(last_checked) - int'(newest);
    if (delta < int'(tolerance)) begin
      if (run != '1) run++;
    end else begin
      run = '0;
    end
    last_checked = newest;
    rep.skipped  = (run >= limit);
    if (!rep.skipped) begin
      for (int i = 0; i < n; i++) begin
        prev  = int'(level);
        cur   = int'(burst[COUNT_W + SB*i +: SB]);
        level = cur[SB-1:0];
        if (!rise_hold && prev <= int'(upper_lvl) && cur > int'(upper_lvl)) begin
          edges++;
          rise_hold = 1'b1;
          fall_hold = 1'b0;
        end else if (!fall_hold && prev >= int'(lower_lvl) && cur < int'(lower_lvl)) begin
          edges++;
          fall_hold = 1'b1;
          rise_hold = 1'b0;
        end
        // low re-arm level may go negative, then nothing clears the rise hold
        if (rise_hold && cur < int'(lower_lvl) - int'(margin)) rise_hold = 1'b0;
        if (fall_hold && cur > int'(upper_lvl) + int'(margin)) fall_hold = 1'b0;
      end
    end
    rep.edges = edges;
    rep.level = level;
    rep.run   = run;
    return rep;
  endfunction

  function automatic int field_check(input string name, input logic [EDGE_W-1:0] exp_v,
                                     input logic [EDGE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_lvl    <= UPPER_RST;
      lower_lvl    <= LOWER_RST;
      tolerance    <= TOL_RST;
      limit        <= LIMIT_RST;
      margin       <= MARGIN_RST;
      edges        <= '0;
      level        <= '0;
      last_checked <= '0;
      rise_hold    <= 1'b0;
      fall_hold    <= 1'b0;
      run          <= '0;
      burst_reports_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_UPPER:  upper_lvl = cfg_data_i;
          CFG_LOWER:  lower_lvl = cfg_data_i;
          CFG_TOL:    tolerance = cfg_data_i;
          CFG_LIMIT:  limit     = cfg_data_i[LIMIT_W-1:0];
          CFG_MARGIN: margin    = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) burst_reports_q.push_back(predict_burst(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.edges   = m_tdata_i[EDGE_W-1:0];
        got.level   = m_tdata_i[LVL_LO +: SB];
        got.run     = m_tdata_i[RUN_LO +: RUN_W];
        got.skipped = m_tuser_i;
        if (burst_reports_q.size() == 0) begin
          $display("%0t: report with no burst pending, edge_total %0d", $time, got.edges);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = burst_reports_q.pop_front();
          fail_count_o = fail_count_o
                       + field_check("edge_total", want.edges, got.edges)
                       + field_check("burst_skipped", EDGE_W'(want.skipped),
                                     EDGE_W'(got.skipped))
                       + field_check("current_level", EDGE_W'(want.level), EDGE_W'(got.level))
                       + field_check("still_run", EDGE_W'(want.run), EDGE_W'(got.run));
        end
      end
      pending_o = burst_reports_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the analog encoder edge counter: a directed pass over the
// threshold, tolerance, limit and margin extremes, then random register
// settings with mostly wave-like and still bursts, with random idle gaps on
// the burst sender and random stalls on the report receiver.
// ----------------------------------------------------------------------------
module tb;
  import aeec_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS_DEF;
  localparam int unsigned IN_TW  = ((COUNT_W + BURST_LEN_DEF * SB + 7) / 8) * 8;
  localparam int unsigned OUT_TW = ((EDGE_W + SB + RUN_W + 7) / 8) * 8;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_TW-1:0]  s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata_o;
  logic              m_axis_tuser_o;

  int pending, fail_count;
  int rx_stall = 0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;
  int wave_lvl = 2000;
  int wave_dir = 1;
  int unsigned last_sent = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  analog_encoder_edge_counter u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  edge_count_checker #(.IN_TW(IN_TW), .OUT_TW(OUT_TW)) u_chk (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 30) rx_stall = idle_len();
    end
  end

  function automatic logic [IN_TW-1:0] burst_pattern(input logic [COUNT_W-1:0] n,
                                                     input int unsigned a, input int unsigned b);
    logic [IN_TW-1:0] data;
    data = '0;
    data[COUNT_W-1:0] = n;
    for (int i = 0; i < BURST_LEN_DEF; i++) data[COUNT_W + SB*i +: SB] = SB'((i % 2) ? b : a);
    return data;
  endfunction

  function automatic logic [IN_TW-1:0] noise_burst(input logic [COUNT_W-1:0] n);
    logic [IN_TW-1:0] data;
    data = '0;
    data[COUNT_W-1:0] = n;
    for (int i = 0; i < BURST_LEN_DEF; i++) data[COUNT_W + SB*i +: SB] = SB'($urandom);
    return data;
  endfunction

  // mostly a wandering wave that sweeps across the thresholds, some bursts held
  // near the last level so the still run builds up, the rest pure noise
  task automatic next_random_burst(output logic [IN_TW-1:0] data);
    int               r, step, jitter, v;
    int unsigned      used;
    logic [COUNT_W-1:0] n;
    r = $urandom_range(0, 99);
    if (r < 5)       n = '0;
    else if (r < 11) n = COUNT_W'($urandom_range(BURST_LEN_DEF + 1, 15));
    else             n = COUNT_W'($urandom_range(1, BURST_LEN_DEF));
    used = (n == 0) ? 1 : ((n > BURST_LEN_DEF) ? BURST_LEN_DEF : n);
    data = noise_burst(n);
    r = $urandom_range(0, 99);
    if (r < 60) begin
      step = $urandom_range(1, 600);
      for (int i = 0; i < used; i++) begin
        wave_lvl += wave_dir * step;
        if (wave_lvl > 4095) begin
          wave_lvl = 4095;
          wave_dir = -1;
        end else if (wave_lvl < 0) begin
          wave_lvl = 0;
          wave_dir = 1;
        end else if ($urandom_range(0, 15) == 0) begin
          wave_dir = -wave_dir;
        end
        data[COUNT_W + SB*i +: SB] = SB'(wave_lvl);
      end
    end else if (r < 85) begin
      jitter = $urandom_range(0, 40);
      for (int i = 0; i < used; i++) begin
        v = int'(last_sent) + $urandom_range(0, 2 * jitter) - jitter;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        data[COUNT_W + SB*i +: SB] = SB'(v);
      end
    end
    last_sent = data[COUNT_W + SB*(used-1) +: SB];
  endtask

  task automatic drive_burst(input logic [IN_TW-1:0] data);
    int gap;
    @(negedge clk_i);
    gap = (tx_steady || $urandom_range(0, 99) >= 45) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drop valid and wait for every report
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_all(input int unsigned hi, input int unsigned lo, input int unsigned tol,
                         input int unsigned lim, input int unsigned mrg);
    write_reg(CFG_UPPER, CFG_W'(hi));
    write_reg(CFG_LOWER, CFG_W'(lo));
    write_reg(CFG_TOL, CFG_W'(tol));
    write_reg(CFG_LIMIT, CFG_W'(lim));
    write_reg(CFG_MARGIN, CFG_W'(mrg));
  endtask

  task automatic random_bursts(input int num);
    logic [IN_TW-1:0] data;
    for (int k = 0; k < num; k++) begin
      if (k % 30 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      next_random_burst(data);
      drive_burst(data);
    end
  endtask

  initial begin
    int unsigned hi, lo, tol, lim, mrg;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // power-on register values
    drive_burst(burst_pattern(4'd0, 0, 4095));
    drive_burst(burst_pattern(4'd8, 4095, 4095));
    drive_burst(burst_pattern(4'd8, 0, 0));
    drive_burst(burst_pattern(4'd2, 2050, 2051));
    drive_burst(burst_pattern(4'd3, 1950, 1949));
    drive_burst(noise_burst(4'd15));
    drive_burst(noise_burst(4'd9));
    drive_burst(burst_pattern(4'd0, 4000, 0));
    settle();

    // thresholds at the rails, negative re-arm level, zero tolerance
    set_all(4095, 0, 0, 255, 4095);
    drive_burst(burst_pattern(4'd8, 4095, 4095));
    drive_burst(burst_pattern(4'd8, 0, 0));
    drive_burst(burst_pattern(4'd8, 0, 4095));
    drive_burst(noise_burst(4'd8));
    settle();

    // inverted thresholds, full tolerance, limit of one, zero margin
    set_all(0, 4095, 4095, 1, 0);
    drive_burst(burst_pattern(4'd8, 0, 0));
    drive_burst(burst_pattern(4'd8, 4095, 4095));
    drive_burst(burst_pattern(4'd8, 0, 0));
    drive_burst(burst_pattern(4'd0, 100, 0));
    settle();

    // zero limit skips everything; upper data bits must be ignored
    write_reg(CFG_LIMIT, 12'hF00);
    drive_burst(noise_burst(4'd8));
    drive_burst(burst_pattern(4'd5, 4095, 0));
    settle();

    // tight margin so the trigger holds re-arm on every swing
    set_all(2050, 1950, 50, 50, 0);
    drive_burst(burst_pattern(4'd8, 2100, 1900));
    drive_burst(burst_pattern(4'd8, 2051, 1949));
    drive_burst(burst_pattern(4'd8, 2050, 1950));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      hi  = $urandom_range(1000, 4000);
      lo  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : hi - $urandom_range(0, 900);
      tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 120);
      lim = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 10);
      lim = lim | ($urandom_range(0, 15) << LIMIT_W);
      mrg = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 4095);
      set_all(hi, lo, tol, lim, mrg);
      random_bursts(100);
      settle();
    end

    // long still run: the counter saturates at its top and then skips
    set_all(2050, 1950, 4095, 255, 100);
    random_bursts(280);
    settle();

    if (fail_count == 0) begin
      $display("analog_encoder_edge_counter verification clean");
    end else begin
      $display("analog_encoder_edge_counter verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("analog_encoder_edge_counter verification failed");
    $finish;
  end

endmodule

// ===== analog_encoder_edge_counter.f =====
sv/aeec_pkg.sv
sv/analog_encoder_edge_counter.sv
test/edge_count_checker.sv
test/tb.sv
